// ===== rtl/region_box_size_filter_assert.svh =====
// Assertion macros shared by the checker of the box size filter.
// Each macro samples on the rising edge of clk and is held off during rst.
`ifndef REGION_BOX_SIZE_FILTER_ASSERT_SVH
`define REGION_BOX_SIZE_FILTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RBSF_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RBSF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rbsf_pkg.sv =====
package rbsf_pkg;

  // Default clamp bound on image dimensions.
  localparam int MAX_IMAGE_DIM_DEFAULT = 4096;

  // Depth of the plan queue between front and back.
  localparam int PLAN_QUEUE_DEPTH = 2;

  // Register reset values.
  localparam logic [11:0] ROI_X_RESET        = 12'd0;
  localparam logic [11:0] ROI_Y_RESET        = 12'd0;
  localparam logic [12:0] IMAGE_WIDTH_RESET  = 13'd4096;
  localparam logic [12:0] IMAGE_HEIGHT_RESET = 13'd4096;
  localparam logic [12:0] TINY_SIZE_RESET    = 13'd12;
  localparam logic [12:0] SMALL_SIZE_RESET   = 13'd30;
  localparam logic [12:0] LARGE_SIZE_RESET   = 13'd128;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_ROI_X        = 3'd0,
    CFG_ROI_Y        = 3'd1,
    CFG_IMAGE_WIDTH  = 3'd2,
    CFG_IMAGE_HEIGHT = 3'd3,
    CFG_TINY_SIZE    = 3'd4,
    CFG_SMALL_SIZE   = 3'd5,
    CFG_LARGE_SIZE   = 3'd6
  } cfg_index_t;

  // Current register contents.
  typedef struct packed {
    logic [11:0] roi_x;
    logic [11:0] roi_y;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [12:0] tiny_size;
    logic [12:0] small_size;
    logic [12:0] large_size;
  } cfg_t;

  // One input item: a cluster box relative to the region of interest.
  typedef struct packed {
    logic        req_type;
    logic [11:0] box_x;
    logic [11:0] box_y;
    logic [12:0] box_w;
    logic [12:0] box_h;
  } box_t;

  // One result item: clamped corners in the full image.
  typedef struct packed {
    logic [11:0] left;
    logic [11:0] top;
    logic [11:0] right;
    logic [11:0] bottom;
    logic        last;
  } rect_t;

  // A candidate rectangle that has passed the size tests.
  typedef struct packed {
    logic signed [13:0] x;
    logic signed [13:0] y;
    logic signed [15:0] y2;     // top row of the lower square when split
    logic        [13:0] w;
    logic        [13:0] h;
    logic               split;
    logic               valid;
  } cand_t;

  // Work for one box: the first candidate, then the second.
  typedef struct packed {
    cand_t a;
    cand_t b;
  } plan_t;

  // Output sequencer steps.
  typedef enum logic [1:0] {
    PH_A_TOP = 2'd0,
    PH_A_BOT = 2'd1,
    PH_B_TOP = 2'd2,
    PH_B_BOT = 2'd3
  } phase_t;

endpackage

// ===== rtl/rbsf_queue.sv =====
module rbsf_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             nonempty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) begin
      ptr_inc = '0;
    end else begin
      ptr_inc = p + PTR_W'(1);
    end
  endfunction

  assign full     = (count == CNT_W'(DEPTH));
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];

  // Storage is written only at the tail.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/rbsf_front.sv =====
module rbsf_front (
  input  logic           clk,
  input  logic           rst,
  input  rbsf_pkg::cfg_t cfg,
  input  logic           box_valid,
  output logic           box_stall,
  input  rbsf_pkg::box_t box,
  output logic           push,
  output rbsf_pkg::plan_t plan,
  input  logic           full
);

  import rbsf_pkg::*;

  logic        held_valid;
  box_t        held;

  logic        accept;
  logic        consume;
  logic        drop;
  logic        is_small;
  logic [11:0] mx;
  logic [11:0] my;
  cand_t       enl;
  cand_t       orig;

  // Rejection of huge or broad rectangles: w > 2h or w > large_size.
  function automatic logic is_rejected(input logic [13:0] w, input logic [13:0] h,
                                       input logic [12:0] large_lim);
    is_rejected = ({1'b0, w} > {h, 1'b0}) || (w > {1'b0, large_lim});
  endfunction

  // Long rectangles become two squares: h > 2w.
  function automatic logic is_long(input logic [13:0] w, input logic [13:0] h);
    is_long = {1'b0, h} > {w, 1'b0};
  endfunction

  assign box_stall = held_valid && full;
  assign accept    = box_valid && !box_stall;
  assign consume   = held_valid && !full;

  // Size classes of the held box.
  always_comb begin
    drop     = (held.box_w < cfg.tiny_size) || (held.box_h < cfg.tiny_size);
    is_small = (held.box_w > cfg.tiny_size) && (held.box_w < cfg.small_size) &&
               (held.box_h > cfg.tiny_size) && (held.box_h < cfg.small_size);
    mx       = held.box_w[12:1];
    my       = held.box_h[12:1];
  end

  // Enlarged candidate: half the size added on every side.
  always_comb begin
    enl.x     = $signed({2'b00, held.box_x}) - $signed({2'b00, mx});
    enl.y     = $signed({2'b00, held.box_y}) - $signed({2'b00, my});
    enl.w     = {1'b0, held.box_w} + {1'b0, mx, 1'b0};
    enl.h     = {1'b0, held.box_h} + {1'b0, my, 1'b0};
    enl.y2    = 16'(enl.y) + $signed({2'b00, enl.h}) - $signed({2'b00, enl.w});
    enl.split = is_long(enl.w, enl.h);
    enl.valid = !drop && is_small && !is_rejected(enl.w, enl.h, cfg.large_size);
  end

  // Candidate at the box's own size.
  always_comb begin
    orig.x     = $signed({2'b00, held.box_x});
    orig.y     = $signed({2'b00, held.box_y});
    orig.w     = {1'b0, held.box_w};
    orig.h     = {1'b0, held.box_h};
    orig.y2    = $signed({4'b0000, held.box_y}) + $signed({3'b000, held.box_h}) -
                 $signed({3'b000, held.box_w});
    orig.split = is_long(orig.w, orig.h);
    orig.valid = !drop && !held.req_type &&
                 !is_rejected(orig.w, orig.h, cfg.large_size);
  end

  // Small boxes lead with the enlarged candidate; others use the first slot alone.
  always_comb begin
    if (is_small) begin
      plan.a = enl;
      plan.b = orig;
    end else begin
      plan.a = orig;
      plan.b = orig;
      plan.b.valid = 1'b0;
    end
    push = consume && (plan.a.valid || plan.b.valid);
  end

  // Input register: an item with no surviving candidate is simply retired.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (consume) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= box;
    end
  end

endmodule

// ===== rtl/rbsf_back.sv =====
module rbsf_back #(
  parameter int MAX_IMAGE_DIM = rbsf_pkg::MAX_IMAGE_DIM_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  rbsf_pkg::cfg_t  cfg,
  input  logic            nonempty,
  input  rbsf_pkg::plan_t head,
  output logic            pop,
  output logic            rect_valid,
  input  logic            rect_stall,
  output rbsf_pkg::rect_t rect
);

  import rbsf_pkg::*;

  phase_t             phase;
  phase_t             phase_next;
  phase_t             cur_ph;
  logic               started;
  logic               started_next;
  logic               emit;
  logic               done;
  cand_t              sel;
  logic signed [15:0] ry;
  logic        [13:0] rh;
  logic signed [17:0] ax;
  logic signed [17:0] ay;
  logic signed [17:0] bx;
  logic signed [17:0] by;
  logic        [12:0] lim_x;
  logic        [12:0] lim_y;
  rect_t              rect_next;

  // Largest coordinate allowed along one axis.
  function automatic logic [12:0] axis_limit(input logic [12:0] dim);
    if (dim == '0) begin
      axis_limit = '0;
    end else if (32'(dim) > 32'(MAX_IMAGE_DIM)) begin
      axis_limit = 13'(MAX_IMAGE_DIM - 1);
    end else begin
      axis_limit = dim - 13'd1;
    end
  endfunction

  // Clamp to zero .. lim and keep the low twelve bits.
  function automatic logic [11:0] clamp(input logic signed [17:0] p,
                                        input logic [12:0] lim);
    if (p < 0) begin
      clamp = '0;
    end else if (p > $signed({5'b00000, lim})) begin
      clamp = lim[11:0];
    end else begin
      clamp = p[11:0];
    end
  endfunction

  assign emit = nonempty && (!rect_valid || !rect_stall);
  assign pop  = emit && done;

  // Sequencer next state: walk the squares and candidates of the head plan.
  always_comb begin
    cur_ph       = started ? phase : (head.a.valid ? PH_A_TOP : PH_B_TOP);
    done         = 1'b0;
    phase_next   = cur_ph;
    unique case (cur_ph)
      PH_A_TOP: begin
        if (head.a.split) begin
          phase_next = PH_A_BOT;
        end else if (head.b.valid) begin
          phase_next = PH_B_TOP;
        end else begin
          done = 1'b1;
        end
      end
      PH_A_BOT: begin
        if (head.b.valid) begin
          phase_next = PH_B_TOP;
        end else begin
          done = 1'b1;
        end
      end
      PH_B_TOP: begin
        if (head.b.split) begin
          phase_next = PH_B_BOT;
        end else begin
          done = 1'b1;
        end
      end
      PH_B_BOT: begin
        done = 1'b1;
      end
      default: begin
        done = 1'b1;
      end
    endcase
    started_next = emit ? !done : started;
  end

  // Sequencer outputs: geometry of the rectangle for this step.
  always_comb begin
    sel   = (cur_ph == PH_B_TOP || cur_ph == PH_B_BOT) ? head.b : head.a;
    ry    = (cur_ph == PH_A_BOT || cur_ph == PH_B_BOT) ? sel.y2 : 16'(sel.y);
    rh    = sel.split ? sel.w : sel.h;
    ax    = 18'(sel.x) + $signed({6'b000000, cfg.roi_x});
    ay    = 18'(ry) + $signed({6'b000000, cfg.roi_y});
    bx    = ax + $signed({4'b0000, sel.w});
    by    = ay + $signed({4'b0000, rh});
    lim_x = axis_limit(cfg.image_width);
    lim_y = axis_limit(cfg.image_height);
    rect_next.left   = clamp(ax, lim_x);
    rect_next.top    = clamp(ay, lim_y);
    rect_next.right  = clamp(bx, lim_x);
    rect_next.bottom = clamp(by, lim_y);
    rect_next.last   = done;
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_A_TOP;
      started <= 1'b0;
    end else begin
      started <= started_next;
      if (emit) begin
        phase <= phase_next;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rect_valid <= 1'b0;
    end else if (emit) begin
      rect_valid <= 1'b1;
    end else if (!rect_stall) begin
      rect_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rect <= rect_next;
    end
  end

endmodule

// ===== rtl/region_box_size_filter.sv =====
// Box size filter: each accepted box yields zero to four clamped rectangles, the last
// one flagged. A box is taken every cycle while the two-entry plan queue has room; the
// output sequencer then offers one rectangle per plan step, at a sustained rate of one
// rectangle per cycle while the receiver does not stall, set by that single output
// register. Unstalled, a box's first rectangle passes the input register, plan queue
// and output register in turn. Boxes that yield nothing leave no trace on the result
// side. Registers are written by the user only while the block is idle; it does not check.
module region_box_size_filter #(
  parameter int MAX_IMAGE_DIM = rbsf_pkg::MAX_IMAGE_DIM_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write,
  input  logic [2:0]      cfg_index,
  input  logic [12:0]     cfg_data,
  input  logic            box_valid,
  output logic            box_stall,
  input  rbsf_pkg::box_t  box,
  output logic            rect_valid,
  input  logic            rect_stall,
  output rbsf_pkg::rect_t rect
);

  import rbsf_pkg::*;

  localparam int PLAN_W = $bits(plan_t);

  cfg_t              cfg;
  plan_t             push_plan;
  plan_t             head_plan;
  logic              push;
  logic              pop;
  logic              full;
  logic              nonempty;
  logic [PLAN_W-1:0] head_bits;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.roi_x        <= ROI_X_RESET;
      cfg.roi_y        <= ROI_Y_RESET;
      cfg.image_width  <= IMAGE_WIDTH_RESET;
      cfg.image_height <= IMAGE_HEIGHT_RESET;
      cfg.tiny_size    <= TINY_SIZE_RESET;
      cfg.small_size   <= SMALL_SIZE_RESET;
      cfg.large_size   <= LARGE_SIZE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ROI_X:        cfg.roi_x        <= cfg_data[11:0];
        CFG_ROI_Y:        cfg.roi_y        <= cfg_data[11:0];
        CFG_IMAGE_WIDTH:  cfg.image_width  <= cfg_data;
        CFG_IMAGE_HEIGHT: cfg.image_height <= cfg_data;
        CFG_TINY_SIZE:    cfg.tiny_size    <= cfg_data;
        CFG_SMALL_SIZE:   cfg.small_size   <= cfg_data;
        CFG_LARGE_SIZE:   cfg.large_size   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  rbsf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .box_valid (box_valid),
    .box_stall (box_stall),
    .box       (box),
    .push      (push),
    .plan      (push_plan),
    .full      (full)
  );

  rbsf_queue #(
    .WIDTH (PLAN_W),
    .DEPTH (PLAN_QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_plan),
    .full      (full),
    .pop       (pop),
    .head      (head_bits),
    .nonempty  (nonempty)
  );

  assign head_plan = plan_t'(head_bits);

  rbsf_back #(
    .MAX_IMAGE_DIM (MAX_IMAGE_DIM)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .nonempty   (nonempty),
    .head       (head_plan),
    .pop        (pop),
    .rect_valid (rect_valid),
    .rect_stall (rect_stall),
    .rect       (rect)
  );

endmodule

// ===== rtl/rbsf_checker.sv =====
`include "region_box_size_filter_assert.svh"

module rbsf_checker (
  input logic            clk,
  input logic            rst,
  input logic            box_valid,
  input logic            box_stall,
  input logic            rect_valid,
  input logic            rect_stall,
  input rbsf_pkg::rect_t rect
);

  // Clamping is monotonic, so corners never cross.
  `RBSF_ASSERT_IMPLY(a_cols_ordered, rect_valid, rect.left <= rect.right, "left beyond right")
  `RBSF_ASSERT_IMPLY(a_rows_ordered, rect_valid, rect.top <= rect.bottom, "top beyond bottom")

  // A stalled result item stays put.
  `RBSF_ASSERT_NEXT(a_rect_held, rect_valid && rect_stall, rect_valid && $stable(rect), "result moved under stall")

  // Straight out of reset there is nothing to deliver and room for a box.
  `RBSF_ASSERT_IMPLY(a_idle_after_reset, $past(rst) && box_valid, !rect_valid && !box_stall, "not idle after reset")

endmodule

bind region_box_size_filter rbsf_checker u_checker (.*);

// ===== dv/tb_region_box_size_filter.sv =====
`timescale 1ns / 100ps

module tb_region_box_size_filter;
  import rbsf_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 16;
  localparam int LONG_HOLD = 300;
  localparam int RANDOM_PHASES = 11;
  localparam int BOXES_PER_PHASE = 40;
  localparam int PRESSURE_PHASE = 6;
  localparam int MAX_REPORTS = 10;
  localparam logic NORMAL_PASS = 1'b0;
  localparam logic INVERTED_PASS = 1'b1;

  // Expected rectangles for every accepted box, in the order the block must emit them.
  class rect_expectations;
    cfg_t regs;
    rect_t expected_rects[$];
    int mismatches;

    function new();
      regs.roi_x = ROI_X_RESET;
      regs.roi_y = ROI_Y_RESET;
      regs.image_width = IMAGE_WIDTH_RESET;
      regs.image_height = IMAGE_HEIGHT_RESET;
      regs.tiny_size = TINY_SIZE_RESET;
      regs.small_size = SMALL_SIZE_RESET;
      regs.large_size = LARGE_SIZE_RESET;
      mismatches = 0;
    endfunction

    // Register writes keep only as many bits as the register holds.
    function void set_reg(cfg_index_t idx, logic [12:0] value);
      case (idx)
        CFG_ROI_X: regs.roi_x = value[11:0];
        CFG_ROI_Y: regs.roi_y = value[11:0];
        CFG_IMAGE_WIDTH: regs.image_width = value;
        CFG_IMAGE_HEIGHT: regs.image_height = value;
        CFG_TINY_SIZE: regs.tiny_size = value;
        CFG_SMALL_SIZE: regs.small_size = value;
        CFG_LARGE_SIZE: regs.large_size = value;
        default: ;
      endcase
    endfunction

    // A zero dimension counts as one pixel, and no limit goes past the largest image.
    function logic [11:0] clamp_corner(int p, logic [12:0] dim);
      int lim;
      lim = int'(dim);
      if (lim < 1) lim = 1;
      if (lim > MAX_IMAGE_DIM_DEFAULT) lim = MAX_IMAGE_DIM_DEFAULT;
      lim = lim - 1;
      if (p < 0) p = 0;
      if (p > lim) p = lim;
      return p[11:0];
    endfunction

    function void emit_corners(int x, int y, int w, int h);
      rect_t r;
      int ax, ay;
      ax = x + int'(regs.roi_x);
      ay = y + int'(regs.roi_y);
      r.left = clamp_corner(ax, regs.image_width);
      r.top = clamp_corner(ay, regs.image_height);
      r.right = clamp_corner(ax + w, regs.image_width);
      r.bottom = clamp_corner(ay + h, regs.image_height);
      r.last = 1'b0;
      expected_rects.insert(expected_rects.size(), r);
    endfunction

    // Huge, broad and over-wide candidates are rejected; long ones become two squares.
    function void split_candidate(int x, int y, int w, int h);
      int large_lim;
      large_lim = int'(regs.large_size);
      if (w > large_lim && h > large_lim) return;
      if (w > 2 * h) return;
      if (w > large_lim) return;
      if (h > 2 * w) begin
        emit_corners(x, y, w, w);
        emit_corners(x, y + h - w, w, w);
      end else begin
        emit_corners(x, y, w, h);
      end
    endfunction

    function void note_box(box_t b);
      int x, y, w, h, tiny, small_lim, first;
      x = int'(b.box_x);
      y = int'(b.box_y);
      w = int'(b.box_w);
      h = int'(b.box_h);
      tiny = int'(regs.tiny_size);
      small_lim = int'(regs.small_size);
      first = expected_rects.size();
      if (w < tiny || h < tiny) return;
      if (w > tiny && w < small_lim && h > tiny && h < small_lim) begin
        // Small box: enlarged by half its size each side, then the original on the normal pass.
        split_candidate(x - w / 2, y - h / 2, w + 2 * (w / 2), h + 2 * (h / 2));
        if (b.req_type == NORMAL_PASS) split_candidate(x, y, w, h);
      end else if (b.req_type == NORMAL_PASS) begin
        split_candidate(x, y, w, h);
      end
      if (expected_rects.size() > first) begin
        expected_rects[expected_rects.size() - 1].last = 1'b1;
      end
    endfunction

    function void check_rect(rect_t got);
      rect_t want;
      if (expected_rects.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("Unexpected rectangle l=%0d t=%0d r=%0d b=%0d last=%0b",
                   got.left, got.top, got.right, got.bottom, got.last);
        mismatches++;
        return;
      end
      want = expected_rects.pop_front();
      if (got.left !== want.left || got.top !== want.top || got.right !== want.right ||
          got.bottom !== want.bottom || got.last !== want.last) begin
        if (mismatches < MAX_REPORTS) begin
          $display("Rectangle mismatch: expected l=%0d t=%0d r=%0d b=%0d last=%0b",
                   want.left, want.top, want.right, want.bottom, want.last);
          $display("                    got      l=%0d t=%0d r=%0d b=%0d last=%0b",
                   got.left, got.top, got.right, got.bottom, got.last);
        end
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [2:0] cfg_index = CFG_ROI_X;
  logic [12:0] cfg_data = '0;
  logic box_valid = 1'b0;
  logic box_stall;
  box_t box = '0;
  logic rect_valid;
  logic rect_stall = 1'b0;
  rect_t rect;

  bit hold_request = 1'b0;
  logic [12:0] reg_values [0:CFG_LARGE_SIZE];
  rect_expectations rects_due = new();

  region_box_size_filter DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .box_valid(box_valid),
    .box_stall(box_stall),
    .box(box),
    .rect_valid(rect_valid),
    .rect_stall(rect_stall),
    .rect(rect)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Every accepted box and rectangle is seen here, on the edge that accepts it.
  always @(posedge clk) begin
    if (!rst) begin
      if (box_valid && !box_stall) rects_due.note_box(box);
      if (rect_valid && !rect_stall) rects_due.check_rect(rect);
    end
  end

  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // The receiver stalls in segments of varying pattern, and once holds off for a long stretch.
  initial begin : rect_sink
    int seg_left;
    int mode;
    int hold_left;
    int step;
    seg_left = 0;
    mode = 0;
    hold_left = 0;
    step = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (seg_left == 0) begin
        seg_left = $urandom_range(16, 96);
        mode = $urandom_range(0, 3);
      end
      seg_left--;
      step++;
      if (hold_left > 0) begin
        hold_left--;
        rect_stall <= 1'b1;
      end else begin
        case (mode)
          0: rect_stall <= 1'b0;
          1: rect_stall <= ($urandom_range(0, 3) == 0);
          2: rect_stall <= 1'($urandom_range(0, 1));
          default: rect_stall <= ((step % 7) >= 4);
        endcase
      end
    end
  end

  function automatic logic [12:0] side13(int v);
    if (v < 0) return '0;
    if (v > 8191) return 13'h1FFF;
    return v[12:0];
  endfunction

  // Box sides cluster round the size thresholds, with some spread over the whole field.
  function automatic int pick_side(cfg_t c);
    int tiny, lim_small, lim_large;
    tiny = int'(c.tiny_size);
    lim_small = int'(c.small_size);
    lim_large = int'(c.large_size);
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 5))
          0: return tiny - 1;
          1: return tiny;
          2: return tiny + 1;
          3: return lim_small - 1;
          4: return lim_small;
          default: return lim_large + $urandom_range(0, 1);
        endcase
      end
      1, 2: begin
        if (tiny + 1 < lim_small) return $urandom_range(tiny + 1, lim_small - 1);
        return $urandom_range(0, 60);
      end
      3: return $urandom_range(0, lim_large + 20);
      4: return $urandom_range(0, 8191);
      default: return $urandom_range(tiny, (lim_large > tiny) ? lim_large : tiny + 40);
    endcase
  endfunction

  // All registers are written back to back; the write enable stays high across them.
  task automatic load_regs();
    cfg_index_t idx;
    idx = idx.first();
    do begin
      cfg_write <= 1'b1;
      cfg_index <= idx;
      cfg_data <= reg_values[idx];
      rects_due.set_reg(idx, reg_values[idx]);
      @(posedge clk);
      idx = idx.next();
    end while (idx != idx.first());
    cfg_write <= 1'b0;
  endtask

  // Boxes go out in bursts; when gaps are enabled the sender may pause between bursts.
  task automatic send_boxes(input box_t boxes[$], input bit with_gaps);
    int burst;
    int gap;
    burst = $urandom_range(1, 12);
    foreach (boxes[i]) begin
      box <= boxes[i];
      box_valid <= 1'b1;
      @(posedge clk);
      while (box_stall) @(posedge clk);
      burst--;
      if (with_gaps && burst <= 0) begin
        burst = $urandom_range(1, 12);
        gap = $urandom_range(0, 8);
        if (gap > 0) begin
          box_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    box_valid <= 1'b0;
  endtask

  // Wait for every expected rectangle, then for boxes that leave nothing behind.
  // The first edge lets the monitor note the box accepted on the previous one.
  task automatic settle();
    @(posedge clk);
    while (rects_due.expected_rects.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    box_t boxes[$];
    box_t b;
    int wi, hi;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed boxes at the reset settings: thresholds, both passes, every outcome.
    boxes.insert(boxes.size(), box_t'{NORMAL_PASS, 12'd100, 12'd100, 13'd12, 13'd12});
    boxes.insert(boxes.size(), box_t'{NORMAL_PASS, 12'd100, 12'd100, 13'd11, 13'd40});
    boxes.insert(boxes.size(), box_t'{NORMAL_PASS, 12'd100, 12'd100, 13'd40, 13'd11});
    boxes.insert(boxes.size(), box_t'{NORMAL_PASS, 12'd200, 12'd150, 13'd20, 13'd20});
    boxes.insert(boxes.size(), box_t'{INVERTED_PASS, 12'd200, 12'd150, 13'd20, 13'd20});
    boxes.insert(boxes.size(), box_t'{NORMAL_PASS, 12'd300, 12'd300, 13'd13, 13'd29});
    boxes.insert(boxes.size(), box_t'{INVERTED_PASS, 12'd300, 12'd300, 13'd13, 13'd29});
    boxes.insert(boxes.size(), box_t'{INVERTED_PASS, 12'd50, 12'd50, 13'd60, 13'd60});
    boxes.insert(boxes.size(), box_t'{NORMAL_PASS, 12'd50, 12'd50, 13'd100, 13'd210});
    boxes.insert(boxes.size(), box_t'{NORMAL_PASS, 12'd50, 12'd50, 13'd200, 13'd200});
    boxes.insert(boxes.size(), box_t'{NORMAL_PASS, 12'd50, 12'd50, 13'd60, 13'd20});
    boxes.insert(boxes.size(), box_t'{NORMAL_PASS, 12'd50, 12'd50, 13'd130, 13'd100});
    boxes.insert(boxes.size(), box_t'{NORMAL_PASS, 12'd50, 12'd50, 13'd100, 13'd150});
    boxes.insert(boxes.size(), box_t'{NORMAL_PASS, 12'd4095, 12'd4095, 13'd8191, 13'd8191});
    boxes.insert(boxes.size(), box_t'{NORMAL_PASS, 12'd0, 12'd0, 13'd0, 13'd0});
    boxes.insert(boxes.size(), box_t'{NORMAL_PASS, 12'd0, 12'd0, 13'd12, 13'd24});
    boxes.insert(boxes.size(), box_t'{NORMAL_PASS, 12'd0, 12'd0, 13'd12, 13'd25});
    boxes.insert(boxes.size(), box_t'{NORMAL_PASS, 12'd4095, 12'd4095, 13'd64, 13'd64});
    boxes.insert(boxes.size(), box_t'{NORMAL_PASS, 12'd0, 12'd0, 13'd4096, 13'd4096});
    boxes.insert(boxes.size(), box_t'{NORMAL_PASS, 12'd5, 12'd5, 13'd29, 13'd29});
    boxes.insert(boxes.size(), box_t'{NORMAL_PASS, 12'd10, 12'd10, 13'd30, 13'd30});
    boxes.insert(boxes.size(), box_t'{INVERTED_PASS, 12'd4095, 12'd0, 13'd13, 13'd13});
    boxes.insert(boxes.size(), box_t'{NORMAL_PASS, 12'd2048, 12'd2048, 13'd128, 13'd128});
    send_boxes(boxes, 1'b1);
    settle();

    for (int phase = 1; phase <= RANDOM_PHASES; phase++) begin
      case (phase)
        1: begin
          // Offset at the far edge of a zero-sized image, nearly every box counted as small.
          reg_values[CFG_ROI_X] = 13'h1FFF;
          reg_values[CFG_ROI_Y] = 13'h0FFF;
          reg_values[CFG_IMAGE_WIDTH] = 13'd0;
          reg_values[CFG_IMAGE_HEIGHT] = 13'd0;
          reg_values[CFG_TINY_SIZE] = 13'd0;
          reg_values[CFG_SMALL_SIZE] = 13'h1FFF;
          reg_values[CFG_LARGE_SIZE] = 13'h1FFF;
        end
        2: begin
          // Oversized image and the largest tiny bound: almost every box is dropped.
          reg_values[CFG_ROI_X] = 13'd0;
          reg_values[CFG_ROI_Y] = 13'd0;
          reg_values[CFG_IMAGE_WIDTH] = 13'h1FFF;
          reg_values[CFG_IMAGE_HEIGHT] = 13'h1FFF;
          reg_values[CFG_TINY_SIZE] = 13'h1FFF;
          reg_values[CFG_SMALL_SIZE] = 13'd1;
          reg_values[CFG_LARGE_SIZE] = 13'h1FFF;
        end
        3: begin
          // Size bounds out of order, so no box is small.
          reg_values[CFG_ROI_X] = 13'd700;
          reg_values[CFG_ROI_Y] = 13'd300;
          reg_values[CFG_IMAGE_WIDTH] = 13'd1280;
          reg_values[CFG_IMAGE_HEIGHT] = 13'd720;
          reg_values[CFG_TINY_SIZE] = 13'd30;
          reg_values[CFG_SMALL_SIZE] = 13'd12;
          reg_values[CFG_LARGE_SIZE] = 13'd40;
        end
        4: begin
          reg_values[CFG_ROI_X] = ROI_X_RESET;
          reg_values[CFG_ROI_Y] = ROI_Y_RESET;
          reg_values[CFG_IMAGE_WIDTH] = IMAGE_WIDTH_RESET;
          reg_values[CFG_IMAGE_HEIGHT] = IMAGE_HEIGHT_RESET;
          reg_values[CFG_TINY_SIZE] = TINY_SIZE_RESET;
          reg_values[CFG_SMALL_SIZE] = SMALL_SIZE_RESET;
          reg_values[CFG_LARGE_SIZE] = LARGE_SIZE_RESET;
        end
        5: begin
          // Lowest legal settings: a one-pixel image and unit size bounds.
          reg_values[CFG_ROI_X] = 13'd0;
          reg_values[CFG_ROI_Y] = 13'd0;
          reg_values[CFG_IMAGE_WIDTH] = 13'd1;
          reg_values[CFG_IMAGE_HEIGHT] = 13'd1;
          reg_values[CFG_TINY_SIZE] = 13'd1;
          reg_values[CFG_SMALL_SIZE] = 13'd1;
          reg_values[CFG_LARGE_SIZE] = 13'd1;
        end
        default: begin
          reg_values[CFG_ROI_X] = 13'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
                                                                  : $urandom_range(0, 600));
          reg_values[CFG_ROI_Y] = 13'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
                                                                  : $urandom_range(0, 600));
          reg_values[CFG_IMAGE_WIDTH] = 13'(($urandom_range(0, 3) == 0)
                                            ? $urandom_range(0, 8191)
                                            : $urandom_range(200, 4096));
          reg_values[CFG_IMAGE_HEIGHT] = 13'(($urandom_range(0, 3) == 0)
                                             ? $urandom_range(0, 8191)
                                             : $urandom_range(200, 4096));
          reg_values[CFG_TINY_SIZE] = 13'($urandom_range(1, 40));
          reg_values[CFG_SMALL_SIZE] = 13'($urandom_range(reg_values[CFG_TINY_SIZE], 90));
          reg_values[CFG_LARGE_SIZE] = 13'($urandom_range(20, 400));
        end
      endcase
      load_regs();

      // Random boxes shaped to hit every category under the current settings.
      boxes.delete();
      for (int k = 0; k < BOXES_PER_PHASE; k++) begin
        b.req_type = 1'($urandom_range(0, 1));
        b.box_x = 12'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                  : $urandom_range(0, 700));
        b.box_y = 12'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                  : $urandom_range(0, 700));
        wi = pick_side(rects_due.regs);
        case ($urandom_range(0, 5))
          3: hi = 2 * wi + $urandom_range(0, (wi > 0 ? wi : 0) + 2);
          4: begin
            hi = pick_side(rects_due.regs);
            wi = 2 * hi + $urandom_range(0, (hi > 0 ? hi : 0) + 2);
          end
          default: hi = pick_side(rects_due.regs);
        endcase
        b.box_w = side13(wi);
        b.box_h = side13(hi);
        boxes.insert(boxes.size(), b);
      end

      // In the pressure phase the sender offers without pause while the receiver holds off.
      if (phase == PRESSURE_PHASE) hold_request = 1'b1;
      send_boxes(boxes, phase != PRESSURE_PHASE);
      settle();
    end

    if (rects_due.mismatches == 0 && rects_due.expected_rects.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/rbsf_pkg.sv
rtl/rbsf_queue.sv
rtl/rbsf_front.sv
rtl/rbsf_back.sv
rtl/region_box_size_filter.sv
rtl/rbsf_checker.sv
dv/tb_region_box_size_filter.sv
